/* hdl/mrf_pkg.sv */
package mrf_pkg;

    localparam logic [7:0] START_BYTE = 8'h68;

    // Frame byte positions.
    localparam logic [3:0] POS_START      = 4'd0;
    localparam logic [3:0] POS_ADDR_FIRST = 4'd1;
    localparam logic [3:0] POS_ADDR_LAST  = 4'd4;
    localparam logic [3:0] POS_HEADER     = 4'd5;
    localparam logic [3:0] POS_VALUE_FIRST = 4'd7;
    localparam logic [3:0] POS_SUM_LAST   = 4'd10;
    localparam logic [3:0] POS_CHECK      = 4'd11;
    localparam logic [3:0] POS_LAST       = 4'd12;

    typedef enum logic [1:0] {
        STATUS_OK            = 2'd0,
        STATUS_ADDR_MISMATCH = 2'd1,
        STATUS_CHECKSUM      = 2'd2,
        STATUS_HEADER        = 2'd3
    } mrf_status_t;

    // A frame byte tagged with its position in the frame.
    typedef struct packed {
        logic [7:0] rx_byte;
        logic [3:0] pos;
    } mrf_item_t;

    typedef struct packed {
        mrf_status_t status;
        logic [31:0] reading;
    } mrf_result_t;

endpackage

/* hdl/meter_reply_frame_receiver.sv */
// Meter reply frame receiver. Bytes are pushed one per cycle while full is
// low; anything before the 0x68 start byte is dropped, then a 13-byte reply
// frame is collected and one result is queued per frame: status (0 ok, 1
// address mismatch, 2 checksum error, 3 header error) and the little-endian
// reading in tenths, zero unless ok. A bad second start byte at frame byte 5
// gives a header error at once. The block takes one byte per clock while full
// is low, since each byte needs only a compare, an 8-bit add and a shift; a
// frame's last byte is registered in the byte queue and its result in the
// result queue. A framing stage tags each byte with its position and hands
// it through a QUEUE_DEPTH-entry byte queue to the checking stage, which
// writes results into a QUEUE_DEPTH-entry result queue. full rises only when
// both queues back up because pop is held low. meter_address is written with
// meter_address_we and should change only while no frame is in progress.
module meter_reply_frame_receiver #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        meter_address_we,
    input  logic [31:0] meter_address,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  rx_byte,
    input  logic        pop,
    output logic        empty,
    output logic [1:0]  frame_status,
    output logic [31:0] reading_tenths
);

    localparam int ITEM_W   = $bits(mrf_pkg::mrf_item_t);
    localparam int RESULT_W = $bits(mrf_pkg::mrf_result_t);

    logic [31:0]          meter_address_reg;
    logic                 accept;
    logic                 item_push;
    mrf_pkg::mrf_item_t   front_item;
    mrf_pkg::mrf_item_t   back_item;
    logic                 item_empty;
    logic                 item_take;
    logic                 result_full;
    logic                 result_push;
    mrf_pkg::mrf_result_t back_result;
    mrf_pkg::mrf_result_t out_result;

    assign accept = push && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            meter_address_reg <= '0;
        end
        else if (meter_address_we)
        begin
            meter_address_reg <= meter_address;
        end
    end

    mrf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .rx_byte   (rx_byte),
        .item_push (item_push),
        .item      (front_item)
    );

    mrf_fifo #(
        .WIDTH (ITEM_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_item_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (item_push),
        .wdata (front_item),
        .full  (full),
        .pop   (item_take),
        .rdata (back_item),
        .empty (item_empty)
    );

    mrf_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .meter_address (meter_address_reg),
        .item_valid    (!item_empty),
        .item          (back_item),
        .item_take     (item_take),
        .result_full   (result_full),
        .result_push   (result_push),
        .result        (back_result)
    );

    mrf_fifo #(
        .WIDTH (RESULT_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_result_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (result_push),
        .wdata (back_result),
        .full  (result_full),
        .pop   (pop),
        .rdata (out_result),
        .empty (empty)
    );

    assign frame_status   = out_result.status;
    assign reading_tenths = out_result.reading;

endmodule

/* hdl/mrf_fifo.sv */
module mrf_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [PTR_W-1:0] PTR_ONE  = PTR_W'(1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    logic [WIDTH-1:0] data_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_FULL);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = data_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_ONE;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_ONE;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_ONE;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_ONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            data_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

/* hdl/mrf_front.sv */
module mrf_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [7:0]        rx_byte,
    output logic              item_push,
    output mrf_pkg::mrf_item_t item
);

    logic [3:0] pos_reg, pos_next;

    // The frame position depends only on the start byte and the header byte,
    // so framing runs here without waiting for the checks.
    always_comb
    begin
        pos_next     = pos_reg;
        item_push    = 1'b0;
        item.rx_byte = rx_byte;
        item.pos     = pos_reg;
        if (accept)
        begin
            if (pos_reg == mrf_pkg::POS_START)
            begin
                if (rx_byte == mrf_pkg::START_BYTE)
                begin
                    item_push = 1'b1;
                    pos_next  = mrf_pkg::POS_ADDR_FIRST;
                end
            end
            else if (pos_reg > mrf_pkg::POS_LAST)
            begin
                pos_next = mrf_pkg::POS_START;
            end
            else
            begin
                item_push = 1'b1;
                if (pos_reg == mrf_pkg::POS_LAST ||
                    (pos_reg == mrf_pkg::POS_HEADER && rx_byte != mrf_pkg::START_BYTE))
                begin
                    pos_next = mrf_pkg::POS_START;
                end
                else
                begin
                    pos_next = pos_reg + 4'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= mrf_pkg::POS_START;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

endmodule

/* hdl/mrf_back.sv */
module mrf_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [31:0]         meter_address,
    input  logic                item_valid,
    input  mrf_pkg::mrf_item_t  item,
    output logic                item_take,
    input  logic                result_full,
    output logic                result_push,
    output mrf_pkg::mrf_result_t result
);

    logic [7:0]  sum_reg, sum_next;
    logic        addr_ok_reg, addr_ok_next;
    logic [31:0] value_reg, value_next;
    logic [1:0]  addr_idx;
    logic [7:0]  addr_want;

    assign item_take = item_valid && !result_full;
    assign addr_idx  = item.pos[1:0] - 2'd1;
    assign addr_want = meter_address[{addr_idx, 3'b000} +: 8];

    always_comb
    begin
        sum_next       = sum_reg;
        addr_ok_next   = addr_ok_reg;
        value_next     = value_reg;
        result_push    = 1'b0;
        result.status  = mrf_pkg::STATUS_OK;
        result.reading = '0;
        if (item_take)
        begin
            if (item.pos == mrf_pkg::POS_START)
            begin
                sum_next     = item.rx_byte;
                addr_ok_next = 1'b1;
                value_next   = '0;
            end
            else
            begin
                if (item.pos <= mrf_pkg::POS_ADDR_LAST && item.rx_byte != addr_want)
                begin
                    addr_ok_next = 1'b0;
                end
                if (item.pos >= mrf_pkg::POS_VALUE_FIRST && item.pos <= mrf_pkg::POS_SUM_LAST)
                begin
                    value_next = {item.rx_byte, value_reg[31:8]};
                end
                if (item.pos <= mrf_pkg::POS_SUM_LAST)
                begin
                    sum_next = sum_reg + item.rx_byte;
                end
                else if (item.pos == mrf_pkg::POS_CHECK)
                begin
                    sum_next = sum_reg - item.rx_byte;
                end

                if (item.pos == mrf_pkg::POS_HEADER && item.rx_byte != mrf_pkg::START_BYTE)
                begin
                    result_push   = 1'b1;
                    result.status = mrf_pkg::STATUS_HEADER;
                end
                else if (item.pos == mrf_pkg::POS_LAST)
                begin
                    result_push = 1'b1;
                    if (!addr_ok_reg)
                    begin
                        result.status = mrf_pkg::STATUS_ADDR_MISMATCH;
                    end
                    else if (sum_reg != 8'd0)
                    begin
                        result.status = mrf_pkg::STATUS_CHECKSUM;
                    end
                    else
                    begin
                        result.reading = value_reg;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg     <= '0;
            addr_ok_reg <= 1'b1;
            value_reg   <= '0;
        end
        else
        begin
            sum_reg     <= sum_next;
            addr_ok_reg <= addr_ok_next;
            value_reg   <= value_next;
        end
    end

endmodule

/* hdl/mrf_checker.sv */
module mrf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        push,
    input logic        full,
    input logic        pop,
    input logic        empty,
    input logic [1:0]  frame_status,
    input logic [31:0] reading_tenths
);

    // Only a good frame carries a reading.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && frame_status != mrf_pkg::STATUS_OK) |-> reading_tenths == 32'd0)
    else $error("nonzero reading on a failed frame");

    // A waiting result holds until it is popped.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(frame_status) && $stable(reading_tenths)))
    else $error("waiting result changed before pop");

    // The input side can only fill up right after a byte was taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(full) |-> $past(push))
    else $error("full rose without a preceding push");

    // A result cannot appear unless a byte was pushed before it.
    assert property (@(posedge clk) disable iff (!rst_n)
        ($fell(empty) && $past(empty, 2) && $past(empty, 3) && !$past(full, 2)
            && !$past(full, 3)) |-> ($past(push, 2) || $past(push, 3)
            || $past(push, 4) || $past(push, 5)))
    else $error("result appeared with no input");

endmodule

bind meter_reply_frame_receiver mrf_checker u_mrf_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .pop              (pop),
    .empty            (empty),
    .frame_status     (frame_status),
    .reading_tenths   (reading_tenths)
);

/* sim/frame_scoreboard_pkg.sv */
package frame_scoreboard_pkg;

    import mrf_pkg::*;

    class frame_scoreboard;
        logic [31:0] address;
        logic [3:0]  position;
        logic [7:0]  running_sum;
        bit          address_ok;
        logic [31:0] value_shift;
        mrf_result_t pending_q[$];
        int          errors;
        int          bytes_used;
        int          status_count[4];

        function new();
            address     = '0;
            position    = POS_START;
            running_sum = '0;
            address_ok  = 1'b1;
            value_shift = '0;
            errors      = 0;
            bytes_used  = 0;
            foreach (status_count[i])
                status_count[i] = 0;
        endfunction

        // Advances the frame state by one accepted push request and queues the
        // result that the byte completes, if any.
        function void note_request(logic [7:0] b);
            mrf_result_t res;
            if (position == POS_START) begin
                if (b == START_BYTE) begin
                    running_sum = b;
                    address_ok  = 1'b1;
                    value_shift = '0;
                    position    = POS_ADDR_FIRST;
                    bytes_used++;
                end
                return;
            end
            bytes_used++;
            if (position > POS_LAST) begin
                position = POS_START;
                return;
            end
            if (position >= POS_ADDR_FIRST && position <= POS_ADDR_LAST) begin
                if (b != address[8 * (position - POS_ADDR_FIRST) +: 8])
                    address_ok = 1'b0;
            end
            if (position == POS_HEADER && b != START_BYTE) begin
                position    = POS_START;
                res.status  = STATUS_HEADER;
                res.reading = '0;
                pending_q.push_back(res);
                return;
            end
            if (position >= POS_VALUE_FIRST && position <= POS_SUM_LAST)
                value_shift = {b, value_shift[31:8]};
            if (position <= POS_SUM_LAST)
                running_sum += b;
            else if (position == POS_CHECK)
                running_sum -= b;
            if (position == POS_LAST) begin
                position    = POS_START;
                res.reading = '0;
                // An address mismatch is reported even when the sum is also bad.
                if (!address_ok)
                    res.status = STATUS_ADDR_MISMATCH;
                else if (running_sum != 8'd0)
                    res.status = STATUS_CHECKSUM;
                else begin
                    res.status  = STATUS_OK;
                    res.reading = value_shift;
                end
                pending_q.push_back(res);
                return;
            end
            position++;
        endfunction

        function void check_result(mrf_status_t status, logic [31:0] reading);
            mrf_result_t want;
            if (pending_q.size() == 0) begin
                $error("result with no request waiting: frame_status %0d reading_tenths %h",
                       status, reading);
                errors++;
                return;
            end
            want = pending_q.pop_front();
            status_count[int'(want.status)]++;
            if (status !== want.status) begin
                $error("frame_status: expected %0d, actual %0d", want.status, status);
                errors++;
            end
            if (reading !== want.reading) begin
                $error("reading_tenths: expected %h, actual %h", want.reading, reading);
                errors++;
            end
        endfunction
    endclass

endpackage

/* sim/tb_top.sv */
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import mrf_pkg::*;
    import frame_scoreboard_pkg::*;

    typedef logic [7:0] frame_t [13];

    typedef enum {
        SEND_OK,
        SEND_BAD_ADDR,
        SEND_BAD_SUM,
        SEND_BAD_BOTH,
        SEND_BAD_HEADER,
        SEND_CUT,
        SEND_NOISE
    } frame_kind_t;

    localparam int DRAIN_CYCLES = 10;
    localparam int PHASE_BYTES  = 165;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        meter_address_we = 1'b0;
    logic [31:0] meter_address = '0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  rx_byte = '0;
    logic        pop = 1'b0;
    logic        empty;
    logic [1:0]  frame_status;
    logic [31:0] reading_tenths;

    bit              steady = 1'b0;
    int              phases = 0;
    frame_scoreboard sb = new();

    meter_reply_frame_receiver dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .meter_address_we(meter_address_we),
        .meter_address   (meter_address),
        .push            (push),
        .full            (full),
        .rx_byte         (rx_byte),
        .pop             (pop),
        .empty           (empty),
        .frame_status    (frame_status),
        .reading_tenths  (reading_tenths)
    );

    always #10 clk = ~clk;

    // Push is left high between requests so back-to-back bytes need no extra edge.
    task automatic send_byte(input logic [7:0] b);
        if (!steady && $urandom_range(0, 99) < 20) begin
            push <= 1'b0;
            @(posedge clk);
        end
        push    <= 1'b1;
        rx_byte <= b;
        @(posedge clk);
        while (full)
            @(posedge clk);
        sb.note_request(b);
    endtask

    task automatic drain_results();
        push <= 1'b0;
        @(posedge clk);
        while (sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_address(input logic [31:0] a);
        meter_address_we <= 1'b1;
        meter_address    <= a;
        @(posedge clk);
        meter_address_we <= 1'b0;
        sb.address = a;
    endtask

    function automatic logic [31:0] pick_reading();
        case ($urandom_range(0, 9))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h6868_6868;
            default: return $urandom;
        endcase
    endfunction

    function automatic frame_t good_frame(input logic [31:0] addr, input logic [31:0] reading,
                                          input logic [7:0] spare, input logic [7:0] tail);
        frame_t     fr;
        logic [7:0] sum;
        fr[0]  = START_BYTE;
        fr[1]  = addr[7:0];
        fr[2]  = addr[15:8];
        fr[3]  = addr[23:16];
        fr[4]  = addr[31:24];
        fr[5]  = START_BYTE;
        fr[6]  = spare;
        fr[7]  = reading[7:0];
        fr[8]  = reading[15:8];
        fr[9]  = reading[23:16];
        fr[10] = reading[31:24];
        sum = '0;
        for (int i = 0; i <= 10; i++)
            sum += fr[i];
        fr[11] = sum;
        fr[12] = tail;
        return fr;
    endfunction

    function automatic frame_kind_t pick_kind();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)      return SEND_OK;
        else if (r < 65) return SEND_BAD_ADDR;
        else if (r < 74) return SEND_BAD_SUM;
        else if (r < 79) return SEND_BAD_BOTH;
        else if (r < 87) return SEND_BAD_HEADER;
        else if (r < 93) return SEND_CUT;
        else             return SEND_NOISE;
    endfunction

    task automatic send_frame(input frame_kind_t kind);
        frame_t fr;
        int     n;
        int     k;
        fr = good_frame(sb.address, pick_reading(), 8'($urandom), 8'($urandom));
        n  = 13;
        if (kind == SEND_BAD_ADDR || kind == SEND_BAD_BOTH) begin
            k     = $urandom_range(1, 4);
            fr[k] = fr[k] ^ 8'($urandom_range(1, 255));
        end
        if (kind == SEND_BAD_SUM || kind == SEND_BAD_BOTH)
            fr[11] = fr[11] ^ 8'($urandom_range(1, 255));
        if (kind == SEND_BAD_HEADER) begin
            do
                fr[5] = 8'($urandom);
            while (fr[5] == START_BYTE);
            n = 6;
        end
        if (kind == SEND_CUT)
            n = $urandom_range(1, 11);
        if (kind == SEND_NOISE) begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++)
                fr[i] = 8'($urandom);
        end
        for (int i = 0; i < n; i++)
            send_byte(fr[i]);
    endtask

    // Feeds filler until the frame in progress has ended, so that the address
    // never changes in the middle of a frame.
    task automatic close_frame();
        while (sb.position != POS_START)
            send_byte(8'h00);
    endtask

    task automatic run_phase(input logic [31:0] addr, input bit quiet);
        int  target;
        bit  paused;
        write_address(addr);
        steady = quiet;
        phases++;
        paused = 1'b0;
        target = sb.bytes_used + PHASE_BYTES;
        while (sb.bytes_used < target) begin
            send_frame(pick_kind());
            if (!paused && sb.bytes_used >= target - PHASE_BYTES / 2) begin
                drain_results();
                paused = 1'b1;
            end
        end
        close_frame();
        drain_results();
        steady = 1'b0;
    endtask

    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge clk);
            if (rst_n && pop && !empty)
                sb.check_result(mrf_status_t'(frame_status), reading_tenths);
            if (steady)
                pop <= 1'b1;
            else if (stall_left > 0) begin
                stall_left--;
                pop <= 1'b0;
            end
            else if ($urandom_range(0, 199) == 0) begin
                // A longer stall lets both internal queues back up until full rises.
                stall_left = $urandom_range(4, 16);
                pop <= 1'b0;
            end
            else
                pop <= ($urandom_range(0, 99) >= 17);
        end
    end

    initial begin
        frame_t fr;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Hunting noise, a header error, then a frame that carries the start
        // byte as data and the largest reading, at the reset address.
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h67);
        fr = good_frame(32'h0, 32'hFFFF_FFFF, START_BYTE, 8'hFF);
        for (int i = 0; i < 5; i++)
            send_byte(fr[i]);
        send_byte(8'h00);
        for (int i = 0; i < 13; i++)
            send_byte(fr[i]);
        drain_results();

        run_phase(32'hFFFF_FFFF, 1'b1);
        run_phase(32'h0000_0000, 1'b0);
        run_phase($urandom, 1'b0);
        run_phase(32'h6868_6868, 1'b0);
        run_phase($urandom, 1'b0);
        run_phase(32'h8000_0001, 1'b0);

        if (sb.pending_q.size() != 0) begin
            $error("%0d expected results never arrived", sb.pending_q.size());
            sb.errors++;
        end
        $display("Frames checked: %0d ok, %0d address mismatch, %0d checksum, %0d header",
                 sb.status_count[0], sb.status_count[1], sb.status_count[2],
                 sb.status_count[3]);
        $display("%0d frame bytes pushed over %0d meter address settings",
                 sb.bytes_used, phases);
        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        #5ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule
